### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the quaternion block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define EATQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is active.
`define EATQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

### rtl/eatq_pkg.sv
// Package with constants, types and arithmetic helpers of the Euler-to-quaternion block.
package eatq_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 14;
    localparam int TRIG_STEPS = 16;

    localparam int FIELD_W    = 16;
    localparam int WORK_FRAC  = 30;
    localparam int CW         = 34;
    localparam int MW         = 32;
    localparam int PW         = 2 * MW;
    localparam int RW         = 34;
    localparam int SW         = RW + 1;
    localparam int LANES      = 3;
    localparam int STEP_W     = 5;
    localparam int OUT_SHIFT  = WORK_FRAC - FRAC_BITS;

    localparam logic signed [CW-1:0] CORDIC_GAIN_INV = CW'(652032874);
    localparam logic signed [PW-1:0] WORK_HALF  = PW'(1) << (WORK_FRAC - 1);
    localparam logic signed [SW-1:0] ROUND_HALF = (SW'(1) << OUT_SHIFT) >> 1;
    localparam logic signed [SW-1:0] SAT_LIM    = SW'(1) << FRAC_BITS;
    localparam logic signed [FIELD_W-1:0] Q_LIM = FIELD_W'(1) << FRAC_BITS;

    // Arctangent of 2^-i, where 2^32 is one full turn.
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335086,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_lane;

    typedef t_lane [LANES-1:0] t_lanes;

    typedef struct packed {
        logic signed [MW-1:0] ca;
        logic signed [MW-1:0] sa;
        logic signed [MW-1:0] cb;
        logic signed [MW-1:0] sb;
        logic signed [MW-1:0] cc;
        logic signed [MW-1:0] sc;
    } t_trig;

    typedef struct packed {
        logic signed [FIELD_W-1:0] q_w;
        logic signed [FIELD_W-1:0] q_x;
        logic signed [FIELD_W-1:0] q_y;
        logic signed [FIELD_W-1:0] q_z;
    } t_quat;

    // Aligns the angle so that pi is 2^31, then halves it with a floor.
    function automatic logic signed [CW-1:0] half_angle(input logic [FIELD_W-1:0] a);
        logic signed [CW-1:0] e;
        e = CW'($signed(a[ANGLE_BITS-1:0]));
        return (e <<< (32 - ANGLE_BITS)) >>> 1;
    endfunction

    // Rounds a Q4.60 product back to the working fraction, giving a Q4.30 result.
    function automatic logic signed [RW-1:0] round_work(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = (p + WORK_HALF) >>> WORK_FRAC;
        return t[RW-1:0];
    endfunction

    // Rounds to the output fraction and clamps to plus or minus one.
    function automatic logic signed [FIELD_W-1:0] out_word(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = (v + ROUND_HALF) >>> OUT_SHIFT;
        if (r > SAT_LIM) begin
            r = SAT_LIM;
        end else if (r < -SAT_LIM) begin
            r = -SAT_LIM;
        end
        return r[FIELD_W-1:0];
    endfunction

    function automatic logic in_range(input logic signed [FIELD_W-1:0] q);
        return (q <= Q_LIM) && (q >= -Q_LIM);
    endfunction

endpackage

### rtl/eatq_in_if.sv
// Request channel carrying the three Euler angles.
interface eatq_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [eatq_pkg::FIELD_W-1:0]   alpha;
    logic signed [eatq_pkg::FIELD_W-1:0]   beta;
    logic signed [eatq_pkg::FIELD_W-1:0]   gamma;

    modport source (output valid, output alpha, output beta, output gamma, input ready);
    modport sink   (input valid, input alpha, input beta, input gamma, output ready);
endinterface

### rtl/eatq_out_if.sv
// Result channel carrying the four quaternion components.
interface eatq_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [eatq_pkg::FIELD_W-1:0]   q_w;
    logic signed [eatq_pkg::FIELD_W-1:0]   q_x;
    logic signed [eatq_pkg::FIELD_W-1:0]   q_y;
    logic signed [eatq_pkg::FIELD_W-1:0]   q_z;

    modport source (output valid, output q_w, output q_x, output q_y, output q_z, input ready);
    modport sink   (input valid, input q_w, input q_x, input q_y, input q_z, output ready);
endinterface

### rtl/eatq_cordic_cell.sv
// One CORDIC rotation step applied to the three angle lanes, registered.
module eatq_cordic_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [eatq_pkg::STEP_W-1:0]       i_step,
    input  eatq_pkg::t_lanes                  i_lanes,
    output logic                              o_valid,
    output eatq_pkg::t_lanes                  o_lanes
);

    logic             r_valid;
    eatq_pkg::t_lanes r_lanes;
    eatq_pkg::t_lanes n_lanes;

    always_comb begin
        logic signed [eatq_pkg::CW-1:0] dx;
        logic signed [eatq_pkg::CW-1:0] dy;
        logic signed [eatq_pkg::CW-1:0] at;
        for (int l = 0; l < eatq_pkg::LANES; l++) begin
            dx = i_lanes[l].y >>> i_step;
            dy = i_lanes[l].x >>> i_step;
            at = eatq_pkg::CW'(eatq_pkg::ATAN_TURNS[i_step]);
            // A non-negative residual angle rotates in the positive direction.
            if (!i_lanes[l].z[eatq_pkg::CW-1]) begin
                n_lanes[l].x = i_lanes[l].x - dx;
                n_lanes[l].y = i_lanes[l].y + dy;
                n_lanes[l].z = i_lanes[l].z - at;
            end else begin
                n_lanes[l].x = i_lanes[l].x + dx;
                n_lanes[l].y = i_lanes[l].y - dy;
                n_lanes[l].z = i_lanes[l].z + at;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lanes <= n_lanes;
        end
    end

    assign o_valid = r_valid;
    assign o_lanes = r_lanes;

endmodule

### rtl/eatq_prod.sv
// Triple products, sums and output rounding, six registered stages.
module eatq_prod (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  eatq_pkg::t_trig i_trig,
    output logic            o_valid,
    input  logic            i_ready,
    output eatq_pkg::t_quat o_q
);

    localparam int STAGES = 6;

    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] en;

    logic signed [eatq_pkg::PW-1:0] r_s1 [4];
    logic signed [eatq_pkg::MW-1:0] r1_cc, r1_sc, r2_cc, r2_sc;
    logic signed [eatq_pkg::RW-1:0] r_s2 [4];
    logic signed [eatq_pkg::PW-1:0] r_s3 [8];
    logic signed [eatq_pkg::RW-1:0] r_s4 [8];
    logic signed [eatq_pkg::SW-1:0] r_s5 [4];
    eatq_pkg::t_quat                r_q;

    logic signed [eatq_pkg::PW-1:0] n_s1 [4];
    logic signed [eatq_pkg::RW-1:0] n_s2 [4];
    logic signed [eatq_pkg::PW-1:0] n_s3 [8];
    logic signed [eatq_pkg::RW-1:0] n_s4 [8];
    logic signed [eatq_pkg::SW-1:0] n_s5 [4];
    eatq_pkg::t_quat                n_q;
    logic signed [eatq_pkg::MW-1:0] ab [4];

    // A stage loads when it is empty or its contents move on.
    always_comb begin
        en[STAGES-1] = !r_v[STAGES-1] || i_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_comb begin
        // Pair products in order: ca*cb, sa*cb, ca*sb, sa*sb.
        n_s1[0] = i_trig.ca * i_trig.cb;
        n_s1[1] = i_trig.sa * i_trig.cb;
        n_s1[2] = i_trig.ca * i_trig.sb;
        n_s1[3] = i_trig.sa * i_trig.sb;
        for (int k = 0; k < 4; k++) begin
            n_s2[k] = eatq_pkg::round_work(r_s1[k]);
            ab[k]   = $signed(r_s2[k][eatq_pkg::MW-1:0]);
        end
        n_s3[0] = ab[0] * r2_cc;
        n_s3[1] = ab[1] * r2_sc;
        n_s3[2] = ab[2] * r2_sc;
        n_s3[3] = ab[3] * r2_cc;
        n_s3[4] = ab[2] * r2_cc;
        n_s3[5] = ab[3] * r2_sc;
        n_s3[6] = ab[1] * r2_cc;
        n_s3[7] = ab[0] * r2_sc;
        for (int k = 0; k < 8; k++) begin
            n_s4[k] = eatq_pkg::round_work(r_s3[k]);
        end
        n_s5[0] = eatq_pkg::SW'(r_s4[0]) - eatq_pkg::SW'(r_s4[1]);
        n_s5[1] = eatq_pkg::SW'(r_s4[2]) - eatq_pkg::SW'(r_s4[3]);
        n_s5[2] = eatq_pkg::SW'(r_s4[4]) + eatq_pkg::SW'(r_s4[5]);
        n_s5[3] = eatq_pkg::SW'(r_s4[6]) + eatq_pkg::SW'(r_s4[7]);
        n_q.q_w = eatq_pkg::out_word(r_s5[0]);
        n_q.q_x = eatq_pkg::out_word(r_s5[1]);
        n_q.q_y = eatq_pkg::out_word(r_s5[2]);
        n_q.q_z = eatq_pkg::out_word(r_s5[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (en[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s1  <= n_s1;
            r1_cc <= i_trig.cc;
            r1_sc <= i_trig.sc;
        end
        if (en[1]) begin
            r_s2  <= n_s2;
            r2_cc <= r1_cc;
            r2_sc <= r1_sc;
        end
        if (en[2]) begin
            r_s3 <= n_s3;
        end
        if (en[3]) begin
            r_s4 <= n_s4;
        end
        if (en[4]) begin
            r_s5 <= n_s5;
        end
        if (en[5]) begin
            r_q <= n_q;
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[STAGES-1];
    assign o_q     = r_q;

endmodule

### rtl/euler_angles_to_quaternion.sv
// Top level: ZYZ Euler angles to unit quaternion through a row of CORDIC cells.
// Requests pass through one register per CORDIC cell, then the product stages; each stage
// advances when empty or drained, giving one request per cycle unless the output stalls.
// A stalled result holds in the output register while empty upstream stages keep loading.
// Synchronous active-low reset clears only the stage valid bits; nothing else needs clearing.
`include "assert_macros.svh"

module euler_angles_to_quaternion (
    input  logic            i_clk,
    input  logic            i_rst_n,
    eatq_in_if.sink         i_req,
    eatq_out_if.source      o_rsp
);

    localparam int N = eatq_pkg::TRIG_STEPS;

    eatq_pkg::t_lanes c_lanes [N+1];
    logic [N:0]       c_valid;
    logic [N:0]       c_en;
    eatq_pkg::t_trig  trig;
    eatq_pkg::t_quat  q;
    logic             p_ready;

    always_comb begin
        for (int l = 0; l < eatq_pkg::LANES; l++) begin
            c_lanes[0][l].x = eatq_pkg::CORDIC_GAIN_INV;
            c_lanes[0][l].y = '0;
        end
        c_lanes[0][0].z = eatq_pkg::half_angle(i_req.alpha);
        c_lanes[0][1].z = eatq_pkg::half_angle(i_req.beta);
        c_lanes[0][2].z = eatq_pkg::half_angle(i_req.gamma);
    end

    assign c_valid[0] = i_req.valid;

    // Ready ripples back from the product pipeline through the cell row.
    always_comb begin
        c_en[N] = p_ready;
        for (int k = N - 1; k >= 0; k--) begin
            c_en[k] = !c_valid[k+1] || c_en[k+1];
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_cell
        eatq_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (c_en[k]),
            .i_valid (c_valid[k]),
            .i_step  (eatq_pkg::STEP_W'(k)),
            .i_lanes (c_lanes[k]),
            .o_valid (c_valid[k+1]),
            .o_lanes (c_lanes[k+1])
        );
    end

    assign trig.ca = $signed(c_lanes[N][0].x[eatq_pkg::MW-1:0]);
    assign trig.sa = $signed(c_lanes[N][0].y[eatq_pkg::MW-1:0]);
    assign trig.cb = $signed(c_lanes[N][1].x[eatq_pkg::MW-1:0]);
    assign trig.sb = $signed(c_lanes[N][1].y[eatq_pkg::MW-1:0]);
    assign trig.cc = $signed(c_lanes[N][2].x[eatq_pkg::MW-1:0]);
    assign trig.sc = $signed(c_lanes[N][2].y[eatq_pkg::MW-1:0]);

    eatq_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_valid[N]),
        .o_ready (p_ready),
        .i_trig  (trig),
        .o_valid (o_rsp.valid),
        .i_ready (o_rsp.ready),
        .o_q     (q)
    );

    assign i_req.ready = c_en[0];
    assign o_rsp.q_w   = q.q_w;
    assign o_rsp.q_x   = q.q_x;
    assign o_rsp.q_y   = q.q_y;
    assign o_rsp.q_z   = q.q_z;

    `EATQ_ASSERT_IMPLY(a_ready_when_out_empty, i_clk, i_rst_n, !o_rsp.valid, i_req.ready)
    `EATQ_ASSERT_NEXT(a_accept_enters_first_cell, i_clk, i_rst_n, i_req.valid && i_req.ready, c_valid[1])
    `EATQ_ASSERT_IMPLY(a_w_x_in_range, i_clk, i_rst_n, o_rsp.valid, eatq_pkg::in_range(q.q_w) && eatq_pkg::in_range(q.q_x))
    `EATQ_ASSERT_IMPLY(a_y_z_in_range, i_clk, i_rst_n, o_rsp.valid, eatq_pkg::in_range(q.q_y) && eatq_pkg::in_range(q.q_z))

endmodule
